// File: sv/multiserver_job_scheduler_side_slots_assert.svh
// Assertion macros shared by the scheduler checker.
`ifndef MULTISERVER_JOB_SCHEDULER_SIDE_SLOTS_ASSERT_SVH
`define MULTISERVER_JOB_SCHEDULER_SIDE_SLOTS_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MJSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MJSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mjss_pkg.sv
// Shared types and constants of the multiserver job scheduler.
package mjss_pkg;

    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int SIDE_DEPTH_DEF  = 16;

    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [11:0] FREE_MAX        = 12'hFFF;
    localparam logic [11:0] SERVER_RST      = 12'd64;
    localparam logic [4:0]  SIDE_SLOT_RST   = 5'd4;
    localparam logic [3:0]  CLASS_RST       = 4'd2;
    localparam logic [3:0]  TWO_CLASS       = 4'd2;

    localparam logic [1:0] CFG_SERVER = 2'd0;
    localparam logic [1:0] CFG_SIDE   = 2'd1;
    localparam logic [1:0] CFG_CLASS  = 2'd2;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_DEPART  = 1'b1;

    localparam logic ST_STARTED = 1'b0;
    localparam logic ST_DROPPED = 1'b1;

    typedef struct packed {
        logic [2:0]  cls;
        logic [11:0] size;
        logic [31:0] id;
    } t_job;

    typedef struct packed {
        logic        status;
        logic [2:0]  cls;
        logic [31:0] id;
    } t_res;

endpackage

// File: sv/mjss_qmem.sv
// Wait queue storage: one write port, one read port, registered read data.
module mjss_qmem #(
    parameter int DEPTH = mjss_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  mjss_pkg::t_job      i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output mjss_pkg::t_job      o_rdata
);

    mjss_pkg::t_job r_mem [DEPTH];
    mjss_pkg::t_job r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/multiserver_job_scheduler_side_slots.sv
// Multiserver job scheduler with a FIFO wait queue and side slots.
//
// Input channel (i_in_valid / o_in_ready) takes one beat per event: an
// arrival (class, size, id) or a departure (size servers returned). Output
// channel (o_out_valid / i_out_ready) gives one beat per job started, plus a
// drop beat when an arrival hits a full queue; o_last marks the final beat
// of an event. An event with no beat finishes silently.
// An event is handled one at a time: it is accepted, then each side
// entry is examined in turn, then each queue head is read from memory
// and decided on, and at last the held last beat is released. With no
// free server both scans are skipped. The result count per event is capped
// at MAX_RESULTS. One result is held back until the next is known so that
// o_last is exact.
// When the receiver stalls, scheduling halts at the next start until the
// output register frees. o_in_ready rises the cycle after the last beat
// enters the output register.
// Reset (synchronous, active low) empties the queue and side list, loads the
// register defaults and sets the free counts from them. The user must issue
// configuration writes only while the block is idle, which is not enforced.
module multiserver_job_scheduler_side_slots #(
    parameter int QUEUE_DEPTH = mjss_pkg::QUEUE_DEPTH_DEF,
    parameter int SIDE_DEPTH  = mjss_pkg::SIDE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [2:0]  i_job_class,
    input  logic [11:0] i_job_size,
    input  logic [31:0] i_job_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [2:0]  o_started_class,
    output logic [31:0] o_started_id,
    output logic        o_last
);

    localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SA_W  = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
    localparam int SC_W  = $clog2(SIDE_DEPTH + 1);
    localparam int LIM_W = (SC_W > 5) ? SC_W : 5;
    localparam int RES_W = mjss_pkg::RES_W;
    localparam int FSS_RST = (SIDE_DEPTH < int'(mjss_pkg::SIDE_SLOT_RST))
                             ? SIDE_DEPTH : int'(mjss_pkg::SIDE_SLOT_RST);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SIDE  = 3'd1;
    localparam logic [2:0] S_QRD   = 3'd2;
    localparam logic [2:0] S_QEX   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]       r_state;
    logic [4:0]       r_side_slot_count;
    logic [3:0]       r_class_count;
    logic [11:0]      r_free;
    logic [LIM_W-1:0] r_ffs;
    logic [QC_W-1:0]  r_qc;
    logic [QA_W-1:0]  r_head;
    logic [QA_W-1:0]  r_tail;
    logic [SC_W-1:0]  r_sc;
    logic [SC_W-1:0]  r_si;
    logic [RES_W-1:0] r_n;
    mjss_pkg::t_job   r_side [SIDE_DEPTH];
    mjss_pkg::t_res   r_pend;
    logic             r_pend_v;
    mjss_pkg::t_res   r_out;
    logic             r_out_v;
    logic             r_out_last;

    mjss_pkg::t_job   w_in_job;
    mjss_pkg::t_job   w_head_job;
    mjss_pkg::t_job   w_side_job;
    logic             w_accept;
    logic             w_full;
    logic             w_qwe;
    logic             w_qre;
    logic [12:0]      w_free_sum;
    logic [11:0]      w_free_evt;
    logic             w_two;
    logic [LIM_W-1:0] w_lim;
    logic             w_can_emit;
    logic             w_emit;
    mjss_pkg::t_res   w_emit_res;
    logic             w_push;
    logic             w_push_last;
    logic             w_res_room;
    logic             w_side_go;
    logic             w_side_hit;
    logic             w_q_go;
    logic             w_head_fit;
    logic             w_head_move;
    logic [LIM_W-1:0] w_cfg_lim;
    logic [LIM_W-1:0] w_sc_ext;

    assign w_in_job   = '{cls: i_job_class, size: i_job_size, id: i_job_id};
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_qc == QC_W'(QUEUE_DEPTH));
    assign w_qwe      = w_accept && (i_req_type == mjss_pkg::REQ_ARRIVAL) && !w_full;
    assign w_qre      = (r_state == S_QRD) && w_q_go;
    assign w_two      = (r_class_count == mjss_pkg::TWO_CLASS);
    assign w_res_room = (r_n < RES_W'(mjss_pkg::MAX_RESULTS));
    assign w_sc_ext   = LIM_W'(r_sc);
    assign w_side_job = r_side[r_si[SA_W-1:0]];

    mjss_qmem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (QA_W)
    ) u_qmem (
        .i_clk   (i_clk),
        .i_we    (w_qwe),
        .i_waddr (r_tail),
        .i_wdata (w_in_job),
        .i_re    (w_qre),
        .i_raddr (r_head),
        .o_rdata (w_head_job)
    );

    always_comb begin
        w_free_sum = {1'b0, r_free} + {1'b0, i_job_size};
        if (i_req_type == mjss_pkg::REQ_DEPART) begin
            w_free_evt = w_free_sum[12] ? mjss_pkg::FREE_MAX : w_free_sum[11:0];
        end else begin
            w_free_evt = r_free;
        end

        if (LIM_W'(r_side_slot_count) > LIM_W'(SIDE_DEPTH)) begin
            w_lim = LIM_W'(SIDE_DEPTH);
        end else begin
            w_lim = LIM_W'(r_side_slot_count);
        end
        if (LIM_W'(i_cfg_wdata[4:0]) > LIM_W'(SIDE_DEPTH)) begin
            w_cfg_lim = LIM_W'(SIDE_DEPTH);
        end else begin
            w_cfg_lim = LIM_W'(i_cfg_wdata[4:0]);
        end

        w_side_go   = (r_free != 12'd0) && (r_si < r_sc) && w_res_room;
        w_side_hit  = (r_free >= w_side_job.size);
        w_q_go      = (r_qc != '0) && w_res_room && (w_two || (r_free != 12'd0));
        w_head_fit  = (r_free >= w_head_job.size);
        w_head_move = (r_ffs != '0) && (r_sc < SC_W'(SIDE_DEPTH))
                      && (!w_two || (w_head_job.size > 12'd1));

        w_can_emit = !r_pend_v || !r_out_v || i_out_ready;
        w_emit     = 1'b0;
        w_emit_res = '{status: mjss_pkg::ST_STARTED, cls: w_side_job.cls, id: w_side_job.id};
        case (r_state)
            S_IDLE: begin
                w_emit     = w_accept && (i_req_type == mjss_pkg::REQ_ARRIVAL) && w_full;
                w_emit_res = '{status: mjss_pkg::ST_DROPPED, cls: i_job_class, id: i_job_id};
            end
            S_SIDE: begin
                w_emit = w_side_go && w_side_hit && w_can_emit;
            end
            S_QEX: begin
                w_emit     = w_head_fit && w_can_emit;
                w_emit_res = '{status: mjss_pkg::ST_STARTED, cls: w_head_job.cls,
                               id: w_head_job.id};
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase

        // Move the held beat out when a newer one replaces it or at the end.
        w_push_last = (r_state == S_FLUSH);
        w_push      = r_pend_v && (w_emit || w_push_last) && (!r_out_v || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_side_slot_count <= mjss_pkg::SIDE_SLOT_RST;
            r_class_count     <= mjss_pkg::CLASS_RST;
            r_free            <= mjss_pkg::SERVER_RST;
            r_ffs             <= LIM_W'(FSS_RST);
            r_qc              <= '0;
            r_head            <= '0;
            r_tail            <= '0;
            r_sc              <= '0;
            r_si              <= '0;
            r_n               <= '0;
            r_pend_v          <= 1'b0;
            r_out_v           <= 1'b0;
        end else begin
            if (w_push) begin
                r_out_v    <= 1'b1;
                r_out      <= r_pend;
                r_out_last <= w_push_last;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end

            if (w_emit) begin
                r_pend   <= w_emit_res;
                r_pend_v <= 1'b1;
            end else if (w_push) begin
                r_pend_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_free <= w_free_evt;
                        r_si   <= '0;
                        r_n    <= w_emit ? RES_W'(1) : '0;
                        if (w_qwe) begin
                            r_qc   <= r_qc + 1'b1;
                            r_tail <= (r_tail == QA_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : r_tail + 1'b1;
                        end
                        r_state <= (w_free_evt == 12'd0) ? S_FLUSH : S_SIDE;
                    end
                end
                S_SIDE: begin
                    if (!w_side_go) begin
                        r_state <= S_QRD;
                    end else if (w_side_hit) begin
                        if (w_can_emit) begin
                            r_free <= r_free - w_side_job.size;
                            r_n    <= r_n + 1'b1;
                            if (r_ffs < w_lim) begin
                                r_ffs <= r_ffs + 1'b1;
                            end
                            // Close the gap: shift later entries down by one.
                            for (int k = 0; k < SIDE_DEPTH - 1; k++) begin
                                if (SC_W'(k) >= r_si) begin
                                    r_side[k] <= r_side[k + 1];
                                end
                            end
                            r_sc <= r_sc - 1'b1;
                        end
                    end else begin
                        r_si <= r_si + 1'b1;
                    end
                end
                S_QRD: begin
                    r_state <= w_q_go ? S_QEX : S_FLUSH;
                end
                S_QEX: begin
                    if (w_head_fit) begin
                        if (w_can_emit) begin
                            r_free  <= r_free - w_head_job.size;
                            r_n     <= r_n + 1'b1;
                            r_qc    <= r_qc - 1'b1;
                            r_head  <= (r_head == QA_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : r_head + 1'b1;
                            r_state <= S_QRD;
                        end
                    end else if (w_head_move) begin
                        r_side[r_sc[SA_W-1:0]] <= w_head_job;
                        r_sc    <= r_sc + 1'b1;
                        r_ffs   <= r_ffs - 1'b1;
                        r_qc    <= r_qc - 1'b1;
                        r_head  <= (r_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        r_state <= S_QRD;
                    end else begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v || w_push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    mjss_pkg::CFG_SERVER: begin
                        r_free <= i_cfg_wdata;
                    end
                    mjss_pkg::CFG_SIDE: begin
                        r_side_slot_count <= i_cfg_wdata[4:0];
                        r_ffs <= (w_cfg_lim > w_sc_ext) ? w_cfg_lim - w_sc_ext : '0;
                    end
                    mjss_pkg::CFG_CLASS: begin
                        r_class_count <= i_cfg_wdata[3:0];
                    end
                    default: begin
                        r_class_count <= r_class_count;
                    end
                endcase
            end
        end
    end

    assign o_in_ready      = (r_state == S_IDLE) && !r_pend_v;
    assign o_out_valid     = r_out_v;
    assign o_status        = r_out.status;
    assign o_started_class = r_out.cls;
    assign o_started_id    = r_out.id;
    assign o_last          = r_out_last;

endmodule

// File: sv/mjss_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`include "multiserver_job_scheduler_side_slots_assert.svh"

module mjss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_last,
    input logic [31:0] o_started_id
);

    `MJSS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_started_id), "stalled output beat changed")

    `MJSS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready,
        !o_in_ready, "input taken again before the event finished")

    `MJSS_ASSERT_NOW(a_no_accept_mid_event, o_out_valid && !o_last,
        !o_in_ready, "input ready while more beats of the event remain")

endmodule

bind multiserver_job_scheduler_side_slots mjss_checker u_mjss_checker (.*);
